/* rtl/core/pfre_pkg.sv */
package pfre_pkg;
  localparam int FRAME_COUNT_D = 16;
  localparam int PAGE_BITS_D = 16;
  localparam int DATA_BITS_D = 32;
  localparam int USE_BITS = 16;
  localparam int SLOT_BITS = 4;
  localparam int CNT_BITS = 32;
  localparam int CFG_IDX_BITS = 1;
  localparam int CFG_DATA_BITS = 5;

  localparam logic [CFG_IDX_BITS-1:0] REG_POLICY = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAMES = 1'd1;

  localparam logic [1:0] POL_FIFO = 2'd0;
  localparam logic [1:0] POL_CLOCK = 2'd1;
  localparam logic [1:0] POL_LEAST = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SEARCH,
    ST_SWEEP,
    ST_WRITE
  } state_t;
endpackage

/* rtl/core/pfre_ram.sv */
module pfre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/core/page_frame_replacement_engine_core.sv */
// Page frame replacement engine.
// Input: pulse in start with req_type, page_index, write_value and
// backing_value while busy is low; the transaction is taken at that edge.
// Configuration: cfg_we with cfg_index (0 policy, 1 frames in use) and
// cfg_data, to be written only while busy is low; the block does not enforce it.
// Output: out_strobe is high for one cycle with all result fields; the
// receiver cannot stall, so results are never held.
// Page and data words live in two single-port-write RAMs; tag, valid,
// referenced, modified and use counts sit in flops per frame.
// Flow: a hit is busy through a tag match with RAM read, then an update;
// the strobe follows in the next cycle, and the next start is taken once
// busy is low again. A free-frame or FIFO miss takes the same path. Least
// use count adds a scan of one frame per cycle; second chance adds a
// sweep of one frame per cycle until an unreferenced frame is found.
// The registered RAM read ahead of the update is part of every transaction.
// Reset: valid, referenced, modified, use counts, pointers and counters
// clear at once; no clearing pass is needed.
module page_frame_replacement_engine_core #(
  parameter int FRAME_COUNT = pfre_pkg::FRAME_COUNT_D,
  parameter int PAGE_BITS = pfre_pkg::PAGE_BITS_D,
  parameter int DATA_BITS = pfre_pkg::DATA_BITS_D
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_req_type,
  input  logic [PAGE_BITS-1:0]               in_page_index,
  input  logic signed [DATA_BITS-1:0]        in_write_value,
  input  logic signed [DATA_BITS-1:0]        in_backing_value,
  input  logic                               cfg_we,
  input  logic [pfre_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [pfre_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output logic                               out_strobe,
  output logic signed [DATA_BITS-1:0]        out_read_value,
  output logic                               out_was_hit,
  output logic [pfre_pkg::SLOT_BITS-1:0]     out_frame_slot,
  output logic                               out_writeback_valid,
  output logic [PAGE_BITS-1:0]               out_writeback_page,
  output logic signed [DATA_BITS-1:0]        out_writeback_value,
  output logic [pfre_pkg::CNT_BITS-1:0]      out_hit_total,
  output logic [pfre_pkg::CNT_BITS-1:0]      out_miss_total,
  output logic [pfre_pkg::CNT_BITS-1:0]      out_writeback_total
);
  localparam int FB = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int NB = $clog2(FRAME_COUNT + 1);
  localparam int UB = pfre_pkg::USE_BITS;
  localparam int CB = pfre_pkg::CNT_BITS;
  localparam int SB = pfre_pkg::SLOT_BITS;
  localparam logic [UB-1:0] USE_MAX = {UB{1'b1}};

  pfre_pkg::state_t state_r, state_nxt;

  logic [1:0]  policy_r;
  logic [4:0]  frames_r;
  logic [FRAME_COUNT-1:0] valid_r, ref_r, mod_r;
  logic [PAGE_BITS-1:0] tag_r [FRAME_COUNT];
  logic [UB-1:0] use_r [FRAME_COUNT];
  logic [FB-1:0] fifo_r, hand_r;
  logic [CB-1:0] hits_r, misses_r, wbs_r;

  logic is_wr_r;
  logic [PAGE_BITS-1:0] page_r;
  logic [DATA_BITS-1:0] wval_r, bval_r;
  logic hit_r;
  logic [FB-1:0] slot_r, scan_r, best_r;
  logic [NB-1:0] n_act;

  logic ram_we;
  logic [FB-1:0] ram_waddr, ram_raddr;
  logic [PAGE_BITS-1:0] pram_rdata;
  logic [DATA_BITS-1:0] dram_wdata, dram_rdata;

  assign busy = (state_r != pfre_pkg::ST_IDLE);

  always_comb begin
    n_act = NB'(frames_r);
    if (frames_r == 5'd0) n_act = NB'(1);
    if ({27'd0, frames_r} > 32'(FRAME_COUNT)) n_act = NB'(FRAME_COUNT);
  end

  logic hit_c;
  logic [FB-1:0] hslot_c, free_c;
  logic free_ok_c;
  always_comb begin
    hit_c = 1'b0;
    hslot_c = '0;
    free_ok_c = 1'b0;
    free_c = '0;
    for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
      if (NB'(i) < n_act) begin
        if (valid_r[i] && tag_r[i] == page_r) begin
          hit_c = 1'b1;
          hslot_c = FB'(i);
        end
        if (!valid_r[i]) begin
          free_ok_c = 1'b1;
          free_c = FB'(i);
        end
      end
    end
  end

  function automatic logic [FB-1:0] wrap_inc(input logic [FB-1:0] v, input logic [NB-1:0] n);
    logic [NB:0] s;
    s = {1'b0, NB'(v)} + 1'b1;
    return (s >= {1'b0, n}) ? '0 : FB'(s);
  endfunction

  logic [FB-1:0] hand_c, fifo_c;
  assign hand_c = (NB'(hand_r) >= n_act) ? '0 : hand_r;
  assign fifo_c = (NB'(fifo_r) >= n_act) ? '0 : fifo_r;

  logic last_scan;
  assign last_scan = (NB'(scan_r) + NB'(1) >= n_act);

  logic wb_c;
  assign wb_c = !hit_r && valid_r[slot_r] && mod_r[slot_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfre_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pfre_pkg::ST_IDLE: if (start) state_nxt = pfre_pkg::ST_READ;
      pfre_pkg::ST_READ: begin
        if (hit_c || free_ok_c || (policy_r != pfre_pkg::POL_CLOCK &&
            policy_r != pfre_pkg::POL_LEAST)) state_nxt = pfre_pkg::ST_WRITE;
        else if (policy_r == pfre_pkg::POL_CLOCK) state_nxt = pfre_pkg::ST_SWEEP;
        else state_nxt = pfre_pkg::ST_SEARCH;
      end
      pfre_pkg::ST_SEARCH: if (last_scan) state_nxt = pfre_pkg::ST_WRITE;
      pfre_pkg::ST_SWEEP: if (!ref_r[hand_r]) state_nxt = pfre_pkg::ST_WRITE;
      pfre_pkg::ST_WRITE: state_nxt = pfre_pkg::ST_IDLE;
      default: state_nxt = pfre_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= pfre_pkg::POL_FIFO;
      frames_r <= 5'd16;
      valid_r <= '0;
      ref_r <= '0;
      mod_r <= '0;
      fifo_r <= '0;
      hand_r <= '0;
      hits_r <= '0;
      misses_r <= '0;
      wbs_r <= '0;
      out_strobe <= 1'b0;
      for (int i = 0; i < FRAME_COUNT; i++) use_r[i] <= '0;
    end else begin
      out_strobe <= (state_r == pfre_pkg::ST_WRITE);
      if (cfg_we) begin
        unique case (cfg_index)
          pfre_pkg::REG_POLICY: policy_r <= cfg_data[1:0];
          pfre_pkg::REG_FRAMES: frames_r <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        pfre_pkg::ST_READ: begin
          hit_r <= hit_c;
          scan_r <= '0;
          best_r <= '0;
          if (hit_c) slot_r <= hslot_c;
          else if (free_ok_c) slot_r <= free_c;
          else if (policy_r == pfre_pkg::POL_CLOCK) hand_r <= hand_c;
          else if (policy_r != pfre_pkg::POL_LEAST) begin
            slot_r <= fifo_c;
            fifo_r <= wrap_inc(fifo_c, n_act);
          end
        end
        pfre_pkg::ST_SEARCH: begin
          if (use_r[scan_r] < use_r[best_r]) best_r <= scan_r;
          scan_r <= wrap_inc(scan_r, n_act);
          if (last_scan) slot_r <= (use_r[scan_r] < use_r[best_r]) ? scan_r : best_r;
        end
        pfre_pkg::ST_SWEEP: begin
          if (!ref_r[hand_r]) slot_r <= hand_r;
          else begin
            ref_r[hand_r] <= 1'b0;
            hand_r <= wrap_inc(hand_r, n_act);
          end
        end
        pfre_pkg::ST_WRITE: begin
          out_was_hit <= hit_r;
          out_frame_slot <= SB'(slot_r);
          out_writeback_valid <= wb_c;
          out_writeback_page <= wb_c ? pram_rdata : '0;
          out_writeback_value <= wb_c ? dram_rdata : '0;
          out_writeback_total <= wb_c ? wbs_r + 1'b1 : wbs_r;
          valid_r[slot_r] <= 1'b1;
          if (hit_r) begin
            hits_r <= hits_r + 1'b1;
            out_hit_total <= hits_r + 1'b1;
            out_miss_total <= misses_r;
            if (use_r[slot_r] != USE_MAX) use_r[slot_r] <= use_r[slot_r] + 1'b1;
            ref_r[slot_r] <= 1'b1;
            if (is_wr_r) mod_r[slot_r] <= 1'b1;
            out_read_value <= is_wr_r ? '0 : dram_rdata;
          end else begin
            misses_r <= misses_r + 1'b1;
            out_hit_total <= hits_r;
            out_miss_total <= misses_r + 1'b1;
            if (wb_c) wbs_r <= wbs_r + 1'b1;
            mod_r[slot_r] <= is_wr_r;
            tag_r[slot_r] <= page_r;
            if (policy_r == pfre_pkg::POL_LEAST) use_r[slot_r] <= '0;
            if (policy_r == pfre_pkg::POL_CLOCK) ref_r[slot_r] <= 1'b1;
            out_read_value <= is_wr_r ? '0 : bval_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == pfre_pkg::ST_IDLE && start) begin
      is_wr_r <= in_req_type;
      page_r <= in_page_index;
      wval_r <= in_write_value;
      bval_r <= in_backing_value;
    end
  end

  // RAM read address is the chosen slot; read lands in time for ST_WRITE
  always_comb begin
    ram_raddr = slot_r;
    if (state_r == pfre_pkg::ST_READ) begin
      if (hit_c) ram_raddr = hslot_c;
      else if (free_ok_c) ram_raddr = free_c;
      else ram_raddr = fifo_c;
    end else if (state_r == pfre_pkg::ST_SEARCH && last_scan) begin
      ram_raddr = (use_r[scan_r] < use_r[best_r]) ? scan_r : best_r;
    end else if (state_r == pfre_pkg::ST_SWEEP) begin
      ram_raddr = hand_r;
    end
  end

  assign ram_we = (state_r == pfre_pkg::ST_WRITE) && (is_wr_r || !hit_r);
  assign ram_waddr = slot_r;
  assign dram_wdata = is_wr_r ? wval_r : bval_r;

  pfre_ram #(.WIDTH(PAGE_BITS), .DEPTH(1 << FB)) u_page_ram (
    .clk(clk), .we(ram_we && !hit_r), .waddr(ram_waddr), .wdata(page_r),
    .raddr(ram_raddr), .rdata(pram_rdata)
  );

  pfre_ram #(.WIDTH(DATA_BITS), .DEPTH(1 << FB)) u_data_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(dram_wdata),
    .raddr(ram_raddr), .rdata(dram_rdata)
  );

  a_strobe_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pfre_pkg::ST_WRITE |=> out_strobe) else $error("no strobe");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> state_r == pfre_pkg::ST_IDLE) else $error("strobe while busy");
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> NB'(out_frame_slot) < n_act) else $error("slot out of range");
  a_wb_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_writeback_valid |-> !out_was_hit) else $error("wb on hit");
endmodule

/* dv/page_frame_replacement_engine_core_tb.sv */
module page_frame_replacement_engine_core_tb;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               was_hit;
    logic [3:0]         frame_slot;
    logic               writeback_valid;
    logic [15:0]        writeback_page;
    logic signed [31:0] writeback_value;
    logic [31:0]        hit_total;
    logic [31:0]        miss_total;
    logic [31:0]        writeback_total;
  } access_result_t;

  class frame_table_scoreboard;
    bit          valid_q[16];
    logic [15:0] page_q[16];
    logic [31:0] data_q[16];
    bit          refd_q[16];
    bit          dirty_q[16];
    logic [15:0] uses_q[16];
    int unsigned fifo_ptr;
    int unsigned hand;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] wbacks;
    logic [1:0]  policy;
    logic [4:0]  frames;
    access_result_t pending_results[$];
    int errors;

    function new();
      for (int i = 0; i < 16; i++) begin
        valid_q[i] = 0;
        refd_q[i] = 0;
        dirty_q[i] = 0;
        uses_q[i] = 0;
        page_q[i] = 0;
        data_q[i] = 0;
      end
      fifo_ptr = 0;
      hand = 0;
      hits = 0;
      misses = 0;
      wbacks = 0;
      policy = pfre_pkg::POL_FIFO;
      frames = 5'd16;
      errors = 0;
    endfunction

    function void set_reg(logic [pfre_pkg::CFG_IDX_BITS-1:0] idx, logic [4:0] val);
      if (idx == pfre_pkg::REG_POLICY) policy = val[1:0];
      else frames = val;
    endfunction

    function int unsigned choose_victim(int unsigned n);
      int unsigned best;
      for (int i = 0; i < n; i++) if (!valid_q[i]) return i;
      if (policy == pfre_pkg::POL_CLOCK) begin
        if (hand >= n) hand = 0;
        for (int s = 0; s < 2 * n + 1; s++) begin
          if (!valid_q[hand] || !refd_q[hand]) return hand;
          refd_q[hand] = 0;
          hand = (hand + 1 >= n) ? 0 : hand + 1;
        end
        return hand;
      end
      if (policy == pfre_pkg::POL_LEAST) begin
        best = 0;
        for (int i = 1; i < n; i++) if (uses_q[i] < uses_q[best]) best = i;
        return best;
      end
      if (fifo_ptr >= n) fifo_ptr = 0;
      best = fifo_ptr;
      fifo_ptr = (fifo_ptr + 1 >= n) ? 0 : fifo_ptr + 1;
      return best;
    endfunction

    function void note_access(logic wr, logic [15:0] pg, logic [31:0] wv, logic [31:0] bv);
      access_result_t r;
      int unsigned n;
      int unsigned slot;
      bit hit;
      n = (frames < 1) ? 1 : ((frames > 16) ? 16 : frames);
      r = '0;
      hit = 0;
      slot = 0;
      for (int i = 0; i < n; i++) begin
        if (!hit && valid_q[i] && page_q[i] == pg) begin
          hit = 1;
          slot = i;
        end
      end
      if (hit) begin
        hits++;
        if (uses_q[slot] != 16'hFFFF) uses_q[slot]++;
        refd_q[slot] = 1;
        if (wr) begin
          dirty_q[slot] = 1;
          data_q[slot] = wv;
        end else begin
          r.read_value = data_q[slot];
        end
      end else begin
        slot = choose_victim(n);
        if (valid_q[slot] && dirty_q[slot]) begin
          r.writeback_valid = 1;
          r.writeback_page = page_q[slot];
          r.writeback_value = data_q[slot];
          wbacks++;
        end
        page_q[slot] = pg;
        valid_q[slot] = 1;
        dirty_q[slot] = wr;
        data_q[slot] = wr ? wv : bv;
        if (policy == pfre_pkg::POL_LEAST) uses_q[slot] = 0;
        if (policy == pfre_pkg::POL_CLOCK) refd_q[slot] = 1;
        misses++;
        if (!wr) r.read_value = bv;
      end
      r.was_hit = hit;
      r.frame_slot = slot[3:0];
      r.hit_total = hits;
      r.miss_total = misses;
      r.writeback_total = wbacks;
      pending_results.push_back(r);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
    endtask

    task check_result(access_result_t got);
      access_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction", 32'd1, 32'd0);
        return;
      end
      want = pending_results.pop_front();
      if (got.read_value !== want.read_value)
        report_mismatch("read_value", got.read_value, want.read_value);
      if (got.was_hit !== want.was_hit) report_mismatch("was_hit", got.was_hit, want.was_hit);
      if (got.frame_slot !== want.frame_slot)
        report_mismatch("frame_slot", got.frame_slot, want.frame_slot);
      if (got.writeback_valid !== want.writeback_valid)
        report_mismatch("writeback_valid", got.writeback_valid, want.writeback_valid);
      if (got.writeback_page !== want.writeback_page)
        report_mismatch("writeback_page", got.writeback_page, want.writeback_page);
      if (got.writeback_value !== want.writeback_value)
        report_mismatch("writeback_value", got.writeback_value, want.writeback_value);
      if (got.hit_total !== want.hit_total)
        report_mismatch("hit_total", got.hit_total, want.hit_total);
      if (got.miss_total !== want.miss_total)
        report_mismatch("miss_total", got.miss_total, want.miss_total);
      if (got.writeback_total !== want.writeback_total)
        report_mismatch("writeback_total", got.writeback_total, want.writeback_total);
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_req_type;
  logic [15:0] in_page_index;
  logic signed [31:0] in_write_value;
  logic signed [31:0] in_backing_value;
  logic        cfg_we;
  logic [pfre_pkg::CFG_IDX_BITS-1:0]  cfg_index;
  logic [pfre_pkg::CFG_DATA_BITS-1:0] cfg_data;
  logic        out_strobe;
  logic signed [31:0] out_read_value;
  logic        out_was_hit;
  logic [3:0]  out_frame_slot;
  logic        out_writeback_valid;
  logic [15:0] out_writeback_page;
  logic signed [31:0] out_writeback_value;
  logic [31:0] out_hit_total;
  logic [31:0] out_miss_total;
  logic [31:0] out_writeback_total;

  frame_table_scoreboard frame_sb;
  int idle_pct;
  logic [15:0] page_pool[8];

  page_frame_replacement_engine_core i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_page_index(in_page_index),
    .in_write_value(in_write_value), .in_backing_value(in_backing_value),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_strobe(out_strobe), .out_read_value(out_read_value),
    .out_was_hit(out_was_hit), .out_frame_slot(out_frame_slot),
    .out_writeback_valid(out_writeback_valid), .out_writeback_page(out_writeback_page),
    .out_writeback_value(out_writeback_value), .out_hit_total(out_hit_total),
    .out_miss_total(out_miss_total), .out_writeback_total(out_writeback_total)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    access_result_t got;
    if (rst_n && out_strobe) begin
      got.read_value = out_read_value;
      got.was_hit = out_was_hit;
      got.frame_slot = out_frame_slot;
      got.writeback_valid = out_writeback_valid;
      got.writeback_page = out_writeback_page;
      got.writeback_value = out_writeback_value;
      got.hit_total = out_hit_total;
      got.miss_total = out_miss_total;
      got.writeback_total = out_writeback_total;
      frame_sb.check_result(got);
    end
  end

  task automatic write_reg(logic [pfre_pkg::CFG_IDX_BITS-1:0] idx, logic [4:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    frame_sb.set_reg(idx, val);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (frame_sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic issue_access(logic wr, logic [15:0] pg, logic [31:0] wv, logic [31:0] bv);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    start <= 1'b1;
    in_req_type <= wr;
    in_page_index <= pg;
    in_write_value <= wv;
    in_backing_value <= bv;
    @(posedge clk);
    while (busy) @(posedge clk);
    frame_sb.note_access(wr, pg, wv, bv);
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(int count, int npages);
    logic [15:0] pg;
    for (int k = 0; k < 8; k++) page_pool[k] = 16'($urandom);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(9) == 0) pg = 16'($urandom);
      else pg = page_pool[$urandom_range(npages - 1)];
      issue_access(1'($urandom_range(1)), pg, $urandom, $urandom);
    end
  endtask

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    frame_sb = new();
    idle_pct = 0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_req_type <= 1'b0;
    in_page_index <= '0;
    in_write_value <= '0;
    in_backing_value <= '0;
    cfg_we <= 1'b0;
    cfg_index <= pfre_pkg::REG_POLICY;
    cfg_data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(pfre_pkg::REG_FRAMES, 5'd2);
    issue_access(1'b0, 16'h0000, 32'h0, 32'h7FFFFFFF);
    issue_access(1'b1, 16'hFFFF, 32'h80000000, 32'h0);
    issue_access(1'b0, 16'hFFFF, 32'h0, 32'h12345678);
    issue_access(1'b1, 16'h0000, 32'hFFFFFFFF, 32'h0);
    issue_access(1'b0, 16'h5555, 32'hAAAAAAAA, 32'h55555555);
    issue_access(1'b1, 16'hAAAA, 32'h55555555, 32'hAAAAAAAA);
    drain();
    write_reg(pfre_pkg::REG_POLICY, 5'(pfre_pkg::POL_CLOCK));
    write_reg(pfre_pkg::REG_FRAMES, 5'd0);
    issue_access(1'b1, 16'h0001, 32'h1, 32'h2);
    issue_access(1'b0, 16'h0002, 32'h3, 32'h4);
    drain();
    write_reg(pfre_pkg::REG_FRAMES, 5'd3);
    for (int k = 0; k < 6; k++) issue_access(k[0], 16'(k % 4), $urandom, $urandom);
    drain();
    write_reg(pfre_pkg::REG_POLICY, 5'(pfre_pkg::POL_LEAST));
    for (int k = 0; k < 5; k++) issue_access(1'b0, 16'(k % 5), $urandom, $urandom);
    drain();
    write_reg(pfre_pkg::REG_POLICY, 5'd3);
    write_reg(pfre_pkg::REG_FRAMES, 5'd31);
    issue_access(1'b1, 16'h0100, $urandom, $urandom);
    issue_access(1'b0, 16'h0100, $urandom, $urandom);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 70;
        2: idle_pct = 0;
        default: idle_pct = 33;
      endcase
      write_reg(pfre_pkg::REG_POLICY, 5'(ph % 3));
      case (ph % 4)
        0: write_reg(pfre_pkg::REG_FRAMES, 5'd16);
        1: write_reg(pfre_pkg::REG_FRAMES, 5'd1);
        2: write_reg(pfre_pkg::REG_FRAMES, 5'($urandom_range(2, 8)));
        default: write_reg(pfre_pkg::REG_FRAMES, 5'($urandom_range(0, 31)));
      endcase
      random_phase(110, (ph % 2 == 0) ? 8 : 4);
      drain();
    end

    drain();
    if (frame_sb.errors == 0 && frame_sb.pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
